// ===== rtl/dq_pkg.sv =====
// Shared types, operation codes and status codes for the double-ended queue.
package dq_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [2:0]               op_t;
    typedef logic [1:0]               status_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_REAR  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_REAR   = 3'd3;
    localparam op_t OP_PEEK_FRONT = 3'd4;
    localparam op_t OP_PEEK_REAR  = 3'd5;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // Commands broadcast to every cell of the chain; at most one is set.
    typedef struct packed {
        logic shift_in_front;  // push front: every word moves one cell to the rear
        logic shift_out_front; // pop front: every word moves one cell to the front
        logic push_rear;       // the first free cell takes the new word
        logic pop_rear;        // the last occupied cell empties itself
    } cell_ctrl_t;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the queue chain: a word, its valid bit and neighbour handover.
module dq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dq_pkg::cell_ctrl_t ctrl,
    input  dq_pkg::data_t      push_value,
    input  dq_pkg::data_t      left_data,
    input  logic               left_valid,
    input  dq_pkg::data_t      right_data,
    input  logic               right_valid,
    output dq_pkg::data_t      data,
    output logic               valid,
    output dq_pkg::data_t      rear_data
);
    import dq_pkg::*;

    data_t data_reg;
    data_t data_next;
    logic  valid_reg;
    logic  valid_next;
    logic  is_rear;
    logic  is_first_free;

    // Occupied cells always form an unbroken run from the front cell.
    assign is_rear       = valid_reg & ~right_valid;
    assign is_first_free = ~valid_reg & left_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift_in_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.shift_out_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.push_rear && is_first_free)
        begin
            data_next  = push_value;
            valid_next = 1'b1;
        end
        else if (ctrl.pop_rear && is_rear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign rear_data = is_rear ? data_reg : '0;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: a chain of DEPTH cells with the front at cell zero.
// An accepted word's result is written to the output register in the next cycle.
// Throughput: one word per cycle unless out_ready stalls; all cells update in one step.
// The rear word is picked by the one cell that sees an empty neighbour behind it.
// Reset clears all valid bits, the item count and the output register at once.
// Cell data registers are not reset and are read only once written.
module double_ended_queue_core #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dq_pkg::op_t                operation,
    input  dq_pkg::data_t              value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dq_pkg::data_t              read_value,
    output dq_pkg::status_t            status,
    output logic [$clog2(DEPTH+1)-1:0] item_count
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    data_t            data_vec   [DEPTH];
    data_t            rear_vec   [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    cell_ctrl_t       ctrl;

    logic             in_fire;
    logic             full;
    logic             empty;
    data_t            front_word;
    data_t            rear_word;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    data_t            read_value_reg;
    data_t            read_value_next;
    status_t          status_reg;
    status_t          status_next;

    assign in_ready   = ~out_valid_reg | out_ready;
    assign in_fire    = in_valid & in_ready;
    assign full       = valid_vec[DEPTH-1];
    assign empty      = ~valid_vec[0];
    assign front_word = data_vec[0];

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            data_t left_data;
            logic  left_valid;
            data_t right_data;
            logic  right_valid;

            if (i == 0)
            begin : g_first
                // The front cell sees the incoming word as its left neighbour.
                assign left_data  = value;
                assign left_valid = 1'b1;
            end
            else
            begin : g_mid_left
                assign left_data  = data_vec[i-1];
                assign left_valid = valid_vec[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_data  = data_vec[i+1];
                assign right_valid = valid_vec[i+1];
            end

            dq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .push_value  (value),
                .left_data   (left_data),
                .left_valid  (left_valid),
                .right_data  (right_data),
                .right_valid (right_valid),
                .data        (data_vec[i]),
                .valid       (valid_vec[i]),
                .rear_data   (rear_vec[i])
            );
        end
    endgenerate

    // At most one cell drives a non-zero rear word, so an OR merges them.
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | rear_vec[i];
        end
    end

    always_comb
    begin
        ctrl            = '0;
        count_next      = count_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        if (in_fire)
        begin
            out_valid_next  = 1'b1;
            read_value_next = '0;
            status_next     = ST_OK;
            unique case (operation)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.shift_in_front = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.push_rear = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.shift_out_front = 1'b1;
                        read_value_next      = front_word;
                        count_next           = count_reg - CNT_W'(1);
                    end
                end
                OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.pop_rear   = 1'b1;
                        read_value_next = rear_word;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                OP_PEEK_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        read_value_next = front_word;
                    end
                end
                OP_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        read_value_next = rear_word;
                    end
                end
                default:
                begin
                    // Unused codes leave the queue untouched and report the count.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign item_count = count_reg;

    // The count register must agree with the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_vec)))
        else $error("item count differs from occupied cells");

    // Occupied cells form one run starting at the front cell.
    a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("gap in the chain of occupied cells");

    // An overflow is only ever reported with the queue full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OVERFLOW) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("overflow reported while not full");

    // A pop on an empty queue never changes the count and always reads zero.
    a_underflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && empty && (operation == OP_POP_FRONT || operation == OP_POP_REAR))
        |=> (count_reg == '0 && read_value_reg == '0 && status_reg == ST_UNDERFLOW))
        else $error("pop on empty queue altered state");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the double-ended queue core: directed table, then random traffic.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_PRINTS = 60;

    // Codes the block does not define; they must leave the store alone.
    localparam op_t OP_SPARE_6 = 3'd6;
    localparam op_t OP_SPARE_7 = 3'd7;

    typedef struct {
        data_t            read_value;
        status_t          status;
        logic [CNT_W-1:0] item_count;
    } deque_result_t;

    // A row with a repeat count above one sends fresh random words each time.
    typedef struct {
        op_t           op;
        data_t         word;
        int            repeats;
        bit            typed;
        deque_result_t want;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    op_t              operation;
    data_t            value;
    logic             out_valid;
    logic             out_ready;
    data_t            read_value;
    status_t          status;
    logic [CNT_W-1:0] item_count;

    // Answer written by hand for the word on the input, if there is one.
    bit               word_typed;
    deque_result_t    word_want;

    // Shadow of the queue held by the predictor.
    data_t            ring_words [DEPTH];
    logic [IDX_W-1:0] head_pos;
    logic [CNT_W-1:0] held_count;

    deque_result_t    pending_results [$];
    int               mismatches;
    int               idle_cycles;

    double_ended_queue_core #(.DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic deque_result_t deque_apply(op_t op, data_t word);
        deque_result_t    res;
        logic [IDX_W-1:0] tail_pos;
        res.read_value = '0;
        res.status     = ST_OK;
        tail_pos       = head_pos + IDX_W'(held_count - 1'b1);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (held_count == CNT_W'(DEPTH))
                    res.status = ST_OVERFLOW;
                else if (op == OP_PUSH_FRONT)
                begin
                    head_pos             = head_pos - 1'b1;
                    ring_words[head_pos] = word;
                    held_count           = held_count + 1'b1;
                end
                else
                begin
                    ring_words[IDX_W'(head_pos + IDX_W'(held_count))] = word;
                    held_count = held_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT:
            begin
                if (held_count == 0)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    res.read_value = ring_words[head_pos];
                    if (op == OP_POP_FRONT)
                    begin
                        head_pos   = head_pos + 1'b1;
                        held_count = held_count - 1'b1;
                    end
                end
            end
            OP_POP_REAR, OP_PEEK_REAR:
            begin
                if (held_count == 0)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    res.read_value = ring_words[tail_pos];
                    if (op == OP_POP_REAR)
                        held_count = held_count - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.item_count = held_count;
        return res;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("tb: %s mismatch at %0t: got %0h, expected %0h", field, $realtime, got, want);
    endtask

    // Predictions are queued before results are checked, so even a combinational
    // result would find its expectation in place.
    always @(posedge clk)
    begin
        deque_result_t predicted;
        deque_result_t oldest;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = deque_apply(operation, value);
                pending_results.push_back(word_typed ? word_want : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    note_mismatch("unexpected result", read_value, '0);
                else
                begin
                    oldest = pending_results.pop_front();
                    if (read_value !== oldest.read_value)
                        note_mismatch("read_value", read_value, oldest.read_value);
                    if (status !== oldest.status)
                        note_mismatch("status", 32'(status), 32'(oldest.status));
                    if (item_count !== oldest.item_count)
                        note_mismatch("item_count", 32'(item_count), 32'(oldest.item_count));
                end
            end
        end
    end

    // The receiver switches at random between always-ready, light and heavy stalling modes.
    always @(posedge clk)
    begin
        int stall_mode;
        int mode_left;
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(8, 48);
        end
        mode_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(op_t op, data_t word, bit typed, deque_result_t want);
        in_valid   <= 1'b1;
        operation  <= op;
        value      <= word;
        word_typed <= typed;
        word_want  <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    int burst_left;

    // Sender side of the idling: after most bursts, lower valid for a random gap.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic data_t random_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return data_t'($urandom());
        endcase
    endfunction

    plan_row_t directed_plan [] = '{
        '{OP_POP_FRONT,  '0,            1,  1, '{'0, ST_UNDERFLOW, 0}},
        '{OP_POP_REAR,   '1,            1,  1, '{'0, ST_UNDERFLOW, 0}},
        '{OP_PEEK_FRONT, '0,            1,  1, '{'0, ST_UNDERFLOW, 0}},
        '{OP_PEEK_REAR,  '1,            1,  1, '{'0, ST_UNDERFLOW, 0}},
        '{OP_SPARE_6,    32'sh1234_5678, 1, 1, '{'0, ST_OK, 0}},
        '{OP_SPARE_7,    '1,            1,  1, '{'0, ST_OK, 0}},
        '{OP_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 1, '{'0, ST_OK, 1}},
        '{OP_PUSH_REAR,  32'sh8000_0000, 1, 1, '{'0, ST_OK, 2}},
        '{OP_PEEK_FRONT, '0,            1,  1, '{32'sh7FFF_FFFF, ST_OK, 2}},
        '{OP_PEEK_REAR,  '0,            1,  1, '{32'sh8000_0000, ST_OK, 2}},
        '{OP_PUSH_FRONT, '1,            1,  0, '{'0, ST_OK, 0}},
        '{OP_PUSH_REAR,  '0,            1,  0, '{'0, ST_OK, 0}},
        '{OP_SPARE_6,    32'sh5A5A_A5A5, 1, 0, '{'0, ST_OK, 0}},
        '{OP_POP_REAR,   '1,            1,  0, '{'0, ST_OK, 0}},
        '{OP_POP_FRONT,  '0,            1,  0, '{'0, ST_OK, 0}},
        '{OP_POP_FRONT,  '0,            1,  0, '{'0, ST_OK, 0}},
        '{OP_POP_REAR,   '0,            1,  1, '{32'sh8000_0000, ST_OK, 0}},
        '{OP_PUSH_REAR,  '0,            63, 0, '{'0, ST_OK, 0}},
        '{OP_PUSH_FRONT, 32'sh0000_0001, 1, 1, '{'0, ST_OK, 64}},
        '{OP_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 1, '{'0, ST_OVERFLOW, 64}},
        '{OP_PUSH_REAR,  32'sh8000_0000, 1, 1, '{'0, ST_OVERFLOW, 64}},
        '{OP_PEEK_FRONT, '0,            1,  1, '{32'sh0000_0001, ST_OK, 64}},
        '{OP_POP_REAR,   '0,            64, 0, '{'0, ST_OK, 0}},
        '{OP_PEEK_REAR,  '0,            1,  1, '{'0, ST_UNDERFLOW, 0}}
    };

    initial
    begin
        deque_result_t no_answer;
        op_t           op;
        bit            filling;
        int            pick;
        no_answer  = '{'0, ST_OK, '0};
        head_pos   = '0;
        held_count = '0;
        mismatches = 0;
        burst_left = 0;
        filling    = 1'b1;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= OP_PUSH_FRONT;
        value      <= '0;
        out_ready  <= 1'b0;
        word_typed <= 1'b0;
        word_want  <= no_answer;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            for (int k = 0; k < directed_plan[i].repeats; k++)
            begin
                send_word(directed_plan[i].op,
                          (directed_plan[i].repeats > 1) ? random_word() : directed_plan[i].word,
                          directed_plan[i].typed, directed_plan[i].want);
                sender_pause();
            end
        end

        // Random part: sweep the queue between empty and full so both limits are hit often.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (filling && held_count == CNT_W'(DEPTH) && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && held_count == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            else if (pick < (filling ? 75 : 25))
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else if (pick < (filling ? 90 : 82))
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            else
                op = $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_REAR;
            send_word(op, random_word(), 1'b0, no_answer);
            sender_pause();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
